@@ src/cot_pkg.sv @@
// Shared constants, codes and types for the cylinder overlap table.
// Used by cot_overlap and cylinder_overlap_table_unit; depends on nothing.
`default_nettype none

package cot_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int ENTRY_W = 6;
  localparam int EXT_W   = (ENTRY_W > CNT_W) ? ENTRY_W : CNT_W;
  localparam int CMD_W   = 3;
  localparam int POS_W   = 32;
  localparam int SIZE_W  = 16;
  localparam int RAD_W   = 15;
  localparam int TALL_W  = 16;
  localparam int SUM_W   = 28;
  localparam int DIFF_W  = POS_W + 1;
  localparam int RS_W    = RAD_W + 1;
  localparam int MAG_W   = RS_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int RS2_W   = 2 * RS_W;
  localparam int SHAPE_W = RAD_W + TALL_W;
  localparam int XYZ_W   = 3 * POS_W;

  localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ENABLE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_PROBE  = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_OWN,
    S_WALK,
    S_DRAIN,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic clear;
    logic vld;
  } ovl_ctl_t;

  typedef struct packed {
    logic                    busy;
    logic                    hit;
    logic signed [SUM_W-1:0] sum_dx;
    logic signed [SUM_W-1:0] sum_dy;
    logic signed [SUM_W-1:0] sum_dz;
  } ovl_stat_t;

endpackage

`default_nettype wire

@@ src/cot_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for every table store; depends on nothing.
`default_nettype none

module cot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/cot_overlap.sv @@
// Pipelined overlap test and offset accumulator, one table entry per cycle.
// Depends on cot_pkg for widths and the control and status structs.
`default_nettype none

module cot_overlap (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cot_pkg::ovl_ctl_t             ctl,
  input  wire logic signed [cot_pkg::POS_W-1:0] px,
  input  wire logic signed [cot_pkg::POS_W-1:0] py,
  input  wire logic signed [cot_pkg::POS_W-1:0] pz,
  input  wire logic [cot_pkg::RAD_W-1:0]     ra,
  input  wire logic [cot_pkg::TALL_W-1:0]    ha,
  input  wire logic signed [cot_pkg::POS_W-1:0] bx,
  input  wire logic signed [cot_pkg::POS_W-1:0] by,
  input  wire logic signed [cot_pkg::POS_W-1:0] bz,
  input  wire logic [cot_pkg::RAD_W-1:0]     brad,
  input  wire logic [cot_pkg::TALL_W-1:0]    btall,
  output cot_pkg::ovl_stat_t                 stat
);

  // Stage A: offsets and radius sum.
  logic                                  a_vld_r;
  logic signed [cot_pkg::DIFF_W-1:0]     a_dx_r, a_dy_r, a_dz_r;
  logic [cot_pkg::RS_W-1:0]              a_rs_r;
  logic [cot_pkg::TALL_W-1:0]            a_tall_r;

  // Stage B: box and height checks, squares.
  logic                                  b_vld_r;
  logic [cot_pkg::SQ_W-1:0]              b_sqx_r, b_sqz_r;
  logic [cot_pkg::RS2_W-1:0]             b_rs2_r;
  logic signed [cot_pkg::SUM_W-1:0]      b_dx_r, b_dy_r, b_dz_r;

  // Accumulator.
  logic                                  hit_r;
  logic signed [cot_pkg::SUM_W-1:0]      sx_r, sy_r, sz_r;

  logic [cot_pkg::DIFF_W-1:0]            abs_dx, abs_dz;
  logic [cot_pkg::MAG_W-1:0]             mag_dx, mag_dz;
  logic signed [cot_pkg::DIFF_W-1:0]     tall_s, neg_ha_s;
  logic                                  in_box, dy_ok;
  logic [cot_pkg::SQ_W:0]                dist2;
  logic                                  inside_c;

  always_comb begin
    abs_dx   = a_dx_r[cot_pkg::DIFF_W-1] ? -a_dx_r : a_dx_r;
    abs_dz   = a_dz_r[cot_pkg::DIFF_W-1] ? -a_dz_r : a_dz_r;
    mag_dx   = abs_dx[cot_pkg::MAG_W-1:0];
    mag_dz   = abs_dz[cot_pkg::MAG_W-1:0];
    in_box   = (abs_dx <= cot_pkg::DIFF_W'(a_rs_r)) && (abs_dz <= cot_pkg::DIFF_W'(a_rs_r));
    tall_s   = $signed(cot_pkg::DIFF_W'(a_tall_r));
    neg_ha_s = -$signed(cot_pkg::DIFF_W'(ha));
    dy_ok    = (a_dy_r <= tall_s) && (a_dy_r >= neg_ha_s);
    dist2    = {1'b0, b_sqx_r} + {1'b0, b_sqz_r};
    inside_c = b_vld_r && (dist2 <= (cot_pkg::SQ_W + 1)'(b_rs2_r));
  end

  always_ff @(posedge clk) begin
    a_dx_r   <= $signed({px[cot_pkg::POS_W-1], px}) - $signed({bx[cot_pkg::POS_W-1], bx});
    a_dy_r   <= $signed({py[cot_pkg::POS_W-1], py}) - $signed({by[cot_pkg::POS_W-1], by});
    a_dz_r   <= $signed({pz[cot_pkg::POS_W-1], pz}) - $signed({bz[cot_pkg::POS_W-1], bz});
    a_rs_r   <= {1'b0, ra} + {1'b0, brad};
    a_tall_r <= btall;
    b_sqx_r  <= mag_dx * mag_dx;
    b_sqz_r  <= mag_dz * mag_dz;
    b_rs2_r  <= a_rs_r * a_rs_r;
    b_dx_r   <= cot_pkg::SUM_W'(a_dx_r);
    b_dy_r   <= cot_pkg::SUM_W'(a_dy_r);
    b_dz_r   <= cot_pkg::SUM_W'(a_dz_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      hit_r   <= 1'b0;
      sx_r    <= '0;
      sy_r    <= '0;
      sz_r    <= '0;
    end else begin
      a_vld_r <= ctl.vld;
      b_vld_r <= a_vld_r && in_box && dy_ok;
      if (ctl.clear) begin
        hit_r <= 1'b0;
        sx_r  <= '0;
        sy_r  <= '0;
        sz_r  <= '0;
      end else if (inside_c) begin
        hit_r <= 1'b1;
        sx_r  <= sx_r + b_dx_r;
        sy_r  <= sy_r + b_dy_r;
        sz_r  <= sz_r + b_dz_r;
      end
    end
  end

  assign stat.busy   = a_vld_r || b_vld_r;
  assign stat.hit    = hit_r;
  assign stat.sum_dx = sx_r;
  assign stat.sum_dy = sy_r;
  assign stat.sum_dz = sz_r;

endmodule

`default_nettype wire

@@ src/cylinder_overlap_table_unit.sv @@
// Cylinder overlap table: entry stores, command sequencer and probe walk.
// Depends on cot_pkg, cot_ram and cot_overlap.
//
// One command beat enters on the in_ channel (valid/ready) and exactly one
// result beat leaves on the out_ channel (valid/ready) for it.
// Add, move, set enable and remove update the table at the input beat.
// These, unused codes and probes of a free entry then go straight from
// idle to the result state, which loads the output register. A probe of an
// entry in use reads its own shape, then walks all ENTRIES table rows through
// the RAM read port, one row per cycle, into the overlap pipeline. The
// sequencer then waits in the drain state until that pipeline is empty,
// passes to the result state and returns to idle once the output register
// is loaded. The walk over the single RAM read port sets the probe time.
// in_ready is high only while the sequencer is idle, so one command is in
// flight at a time. A finished result waits in the output register while
// out_ready is low. The sequencer can still take one new beat meanwhile, but
// it then holds that beat's result and takes nothing further until the
// output register frees.
// Reset marks every entry as not in use; the position, shape and enable
// stores hold no reset value and are only read for entries in use.
`default_nettype none

module cylinder_overlap_table_unit (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic [cot_pkg::CMD_W-1:0]          in_cmd,
  input  wire logic [cot_pkg::ENTRY_W-1:0]        in_entry,
  input  wire logic signed [cot_pkg::POS_W-1:0]   in_pos_x,
  input  wire logic signed [cot_pkg::POS_W-1:0]   in_pos_y,
  input  wire logic signed [cot_pkg::POS_W-1:0]   in_pos_z,
  input  wire logic [cot_pkg::SIZE_W-1:0]         in_size_dx,
  input  wire logic [cot_pkg::SIZE_W-1:0]         in_size_dz,
  input  wire logic [cot_pkg::TALL_W-1:0]         in_body_height,
  input  wire logic                               in_enable_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic                                    out_status,
  output logic                                    out_hit,
  output logic signed [cot_pkg::SUM_W-1:0]        out_sum_dx,
  output logic signed [cot_pkg::SUM_W-1:0]        out_sum_dy,
  output logic signed [cot_pkg::SUM_W-1:0]        out_sum_dz
);

  cot_pkg::state_t                      state_r, state_nxt;
  logic [cot_pkg::IDX_W-1:0]            k_r, k_nxt;
  logic [cot_pkg::IDX_W-1:0]            k1_r;
  logic                                 v1_r;
  logic                                 issue;
  logic [cot_pkg::IDX_W-1:0]            idx_r;
  logic signed [cot_pkg::POS_W-1:0]     px_r, py_r, pz_r;
  logic [cot_pkg::RAD_W-1:0]            ra_r, ra_nxt;
  logic [cot_pkg::TALL_W-1:0]           ha_r, ha_nxt;
  logic [cot_pkg::ENTRIES-1:0]          in_use_r, in_use_nxt;
  logic                                 res_status_r, res_status_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic                                 out_status_r, out_hit_r;
  logic signed [cot_pkg::SUM_W-1:0]     out_sx_r, out_sy_r, out_sz_r;
  logic                                 out_load;

  logic                                 acc;
  logic [cot_pkg::EXT_W-1:0]            entry_ext;
  logic [cot_pkg::IDX_W-1:0]            entry_idx;
  logic                                 entry_ok, entry_used;

  logic [cot_pkg::IDX_W-1:0]            rd_addr;
  logic                                 pos_we, shape_we, en_we;
  logic                                 en_wdata;
  logic [cot_pkg::XYZ_W-1:0]            pos_q;
  logic [cot_pkg::SHAPE_W-1:0]          shape_q;
  logic                                 en_q;

  cot_pkg::ovl_ctl_t                    ovl_ctl;
  cot_pkg::ovl_stat_t                   ovl_stat;

  assign acc        = in_valid && in_ready;
  assign entry_ext  = cot_pkg::EXT_W'(in_entry);
  assign entry_idx  = entry_ext[cot_pkg::IDX_W-1:0];
  assign entry_ok   = entry_ext < cot_pkg::EXT_W'(cot_pkg::ENTRIES);
  assign entry_used = entry_ok && in_use_r[entry_idx];

  cot_ram #(.WIDTH(cot_pkg::XYZ_W), .DEPTH(cot_pkg::ENTRIES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (entry_idx),
    .wdata ({in_pos_x, in_pos_y, in_pos_z}),
    .raddr (rd_addr),
    .rdata (pos_q)
  );

  cot_ram #(.WIDTH(cot_pkg::SHAPE_W), .DEPTH(cot_pkg::ENTRIES)) u_shape_ram (
    .clk   (clk),
    .we    (shape_we),
    .waddr (entry_idx),
    .wdata ({cot_pkg::RAD_W'(({1'b0, in_size_dx} + {1'b0, in_size_dz}) >> 2), in_body_height}),
    .raddr (rd_addr),
    .rdata (shape_q)
  );

  cot_ram #(.WIDTH(1), .DEPTH(cot_pkg::ENTRIES)) u_en_ram (
    .clk   (clk),
    .we    (en_we),
    .waddr (entry_idx),
    .wdata (en_wdata),
    .raddr (rd_addr),
    .rdata (en_q)
  );

  assign ovl_ctl.clear = acc;
  assign ovl_ctl.vld   = v1_r && in_use_r[k1_r] && en_q && (k1_r != idx_r);

  cot_overlap u_overlap (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ovl_ctl),
    .px    (px_r),
    .py    (py_r),
    .pz    (pz_r),
    .ra    (ra_r),
    .ha    (ha_r),
    .bx    ($signed(pos_q[3*cot_pkg::POS_W-1:2*cot_pkg::POS_W])),
    .by    ($signed(pos_q[2*cot_pkg::POS_W-1:cot_pkg::POS_W])),
    .bz    ($signed(pos_q[cot_pkg::POS_W-1:0])),
    .brad  (shape_q[cot_pkg::SHAPE_W-1:cot_pkg::TALL_W]),
    .btall (shape_q[cot_pkg::TALL_W-1:0]),
    .stat  (ovl_stat)
  );

  always_comb begin
    state_nxt      = state_r;
    k_nxt          = k_r;
    ra_nxt         = ra_r;
    ha_nxt         = ha_r;
    in_use_nxt     = in_use_r;
    res_status_nxt = res_status_r;
    in_ready       = 1'b0;
    issue          = 1'b0;
    out_load       = 1'b0;
    pos_we         = 1'b0;
    shape_we       = 1'b0;
    en_we          = 1'b0;
    en_wdata       = 1'b1;
    rd_addr        = entry_idx;
    case (state_r)
      cot_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_status_nxt = 1'b0;
          state_nxt      = cot_pkg::S_RESULT;
          case (in_cmd)
            cot_pkg::CMD_ADD: begin
              if (!entry_ok) begin
                res_status_nxt = 1'b1;
              end else begin
                shape_we = 1'b1;
                if (!in_use_r[entry_idx]) begin
                  pos_we                = 1'b1;
                  en_we                 = 1'b1;
                  in_use_nxt[entry_idx] = 1'b1;
                end
              end
            end
            cot_pkg::CMD_MOVE: begin
              res_status_nxt = !entry_used;
              pos_we         = entry_used;
            end
            cot_pkg::CMD_ENABLE: begin
              res_status_nxt = !entry_used;
              en_we          = entry_used;
              en_wdata       = in_enable_value;
            end
            cot_pkg::CMD_REMOVE: begin
              res_status_nxt = !entry_used;
              if (entry_used) begin
                in_use_nxt[entry_idx] = 1'b0;
              end
            end
            cot_pkg::CMD_PROBE: begin
              res_status_nxt = !entry_used;
              if (entry_used) begin
                state_nxt = cot_pkg::S_OWN;
              end
            end
            default: begin
              res_status_nxt = 1'b0;
            end
          endcase
        end
      end
      cot_pkg::S_OWN: begin
        ra_nxt    = shape_q[cot_pkg::SHAPE_W-1:cot_pkg::TALL_W];
        ha_nxt    = shape_q[cot_pkg::TALL_W-1:0];
        k_nxt     = '0;
        state_nxt = cot_pkg::S_WALK;
      end
      cot_pkg::S_WALK: begin
        rd_addr = k_r;
        issue   = 1'b1;
        k_nxt   = k_r + 1'b1;
        if (k_r == cot_pkg::IDX_W'(cot_pkg::ENTRIES - 1)) begin
          state_nxt = cot_pkg::S_DRAIN;
        end
      end
      cot_pkg::S_DRAIN: begin
        if (!v1_r && !ovl_stat.busy) begin
          state_nxt = cot_pkg::S_RESULT;
        end
      end
      cot_pkg::S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = cot_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = cot_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cot_pkg::S_IDLE;
      k_r         <= '0;
      v1_r        <= 1'b0;
      in_use_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      v1_r        <= issue;
      in_use_r    <= in_use_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k1_r         <= k_r;
    ra_r         <= ra_nxt;
    ha_r         <= ha_nxt;
    res_status_r <= res_status_nxt;
    if (acc) begin
      idx_r <= entry_idx;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      pz_r  <= in_pos_z;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_hit_r    <= ovl_stat.hit;
      out_sx_r     <= ovl_stat.sum_dx;
      out_sy_r     <= ovl_stat.sum_dy;
      out_sz_r     <= ovl_stat.sum_dz;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_hit    = out_hit_r;
  assign out_sum_dx = out_sx_r;
  assign out_sum_dy = out_sy_r;
  assign out_sum_dz = out_sz_r;

  a_probe_owner_in_use: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cot_pkg::S_OWN || state_r == cot_pkg::S_WALK ||
     state_r == cot_pkg::S_DRAIN) |-> in_use_r[idx_r])
    else $error("Probed entry left the table during its walk.");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == cot_pkg::S_IDLE) |-> (!v1_r && !ovl_stat.busy))
    else $error("Overlap pipeline still busy while the sequencer is idle.");

  a_hit_means_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> !out_status_r)
    else $error("Hit reported for a beat whose entry is not in use.");

  a_miss_zero_sums: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_hit_r) |->
      (out_sx_r == '0 && out_sy_r == '0 && out_sz_r == '0))
    else $error("Nonzero offset sums without a hit.");

endmodule

`default_nettype wire
